// ===== rtl/quaternion_alu_defines.svh =====
// assertion macros shared by the quaternion alu rtl
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define QA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/qalu_pkg.sv =====
// shared types and constants for the quaternion alu
`default_nettype none

package qalu_pkg;

    localparam int OUT_W = 34;

    typedef enum logic [2:0] {
        FN_AB     = 3'd0,
        FN_BA     = 3'd1,
        FN_DOT    = 3'd2,
        FN_CONJ_A = 3'd3,
        FN_CONJ_B = 3'd4,
        FN_MAG_A  = 3'd5,
        FN_MAG_B  = 3'd6
    } qalu_func_t;

    // result fields that ride alongside the square root pipe
    typedef struct packed {
        logic signed [OUT_W-1:0] r_w;
        logic signed [OUT_W-1:0] r_x;
        logic signed [OUT_W-1:0] r_y;
        logic signed [OUT_W-1:0] r_z;
        logic signed [OUT_W-1:0] scalar;
        logic                    is_mag;
    } qalu_side_t;

endpackage

`default_nettype wire

// ===== rtl/qalu_isqrt.sv =====
// pipelined floor square root, one root bit per stage, with sideband payload
`default_nettype none
`include "quaternion_alu_defines.svh"

module qalu_isqrt
    import qalu_pkg::*;
#(
    parameter int RAD_W = 33,
    localparam int ROOT_W = (RAD_W + 1) / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire qalu_side_t        in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output qalu_side_t             out_side
);

    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W-1:0] v_reg;
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAD_W-1:0]  rad_reg  [ROOT_W];
    qalu_side_t        side_reg [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_step
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [PAD_W-1:0]  rad_in;
        qalu_side_t        side_in;
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [PAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = PAD_W'(in_rad);
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next radicand digit pair and try root*4+1
        always_comb
        begin
            shifted   = {rem_in[REM_W-3:0], rad_in[PAD_W-1 -: 2]};
            trial     = REM_W'({root_in, 2'b01});
            fits      = (shifted >= trial);
            rem_next  = fits ? (shifted - trial) : shifted;
            root_next = {root_in[ROOT_W-2:0], fits};
            rad_next  = {rad_in[PAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

    `QA_ASSERT_NOW(a_rem_bound, clk, rst_n, out_valid,
        rem_reg[ROOT_W-1] <= REM_W'({out_root, 1'b0}))
    `QA_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(v_reg))
    `QA_ASSERT_NOW(a_root_range, clk, rst_n,
        out_valid && out_side.is_mag && out_root[ROOT_W-1],
        out_root[ROOT_W-2:0] == '0)

endmodule

`default_nettype wire

// ===== rtl/quaternion_alu.sv =====
// quaternion alu top level: operand select, product array, sums, square root, output
//
// Takes one word per cycle while in_ready is high and returns one result
// word per input word, in order. The pipe is an input register, a register
// after the sixteen component multipliers, a register after the four-term sums,
// COMPONENT_WIDTH + 1 square root stages that each settle one root bit, and the
// output register. Every operation takes the same path, so results never reorder.
// The whole pipe advances together; it keeps accepting while a finished result waits
// unless the last square root stage also holds a result, and then in_ready drops.
// Hamilton products, dot product and conjugates are exact and then wrapped to 34 bits;
// magnitude is the floor square root of the sum of squares. Scalar operations return
// zero quaternion fields, quaternion operations return a zero scalar, and the unused
// function code returns all zeros.
`default_nettype none
`include "quaternion_alu_defines.svh"

module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        func,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [OUT_W-1:0]                r_w,
    output logic signed [OUT_W-1:0]                r_x,
    output logic signed [OUT_W-1:0]                r_y,
    output logic signed [OUT_W-1:0]                r_z,
    output logic signed [OUT_W-1:0]                scalar
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int PROD_W = 2 * CW;
    localparam int SUM_W  = 2 * CW + 2;
    localparam int RAD_W  = 2 * CW + 1;
    localparam int ROOT_W = (RAD_W + 1) / 2;

    logic pipe_en;

    // operand select
    logic signed [CW-1:0] a_vec  [4];
    logic signed [CW-1:0] b_vec  [4];
    logic signed [CW-1:0] p_next [4];
    logic signed [CW-1:0] q_next [4];

    logic                 va_reg;
    qalu_func_t           func_a_reg;
    logic signed [CW-1:0] p_a_reg [4];
    logic signed [CW-1:0] q_a_reg [4];

    logic                     vb_reg;
    qalu_func_t               func_b_reg;
    logic signed [CW-1:0]     p_b_reg    [4];
    logic signed [PROD_W-1:0] prod_b_reg [4][4];

    logic signed [SUM_W-1:0] h_w;
    logic signed [SUM_W-1:0] h_x;
    logic signed [SUM_W-1:0] h_y;
    logic signed [SUM_W-1:0] h_z;
    logic signed [SUM_W-1:0] d_sum;
    qalu_side_t              side_next;

    logic             vc_reg;
    qalu_side_t       side_c_reg;
    logic [RAD_W-1:0] rad_c_reg;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    qalu_side_t        sq_side;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] r_w_reg;
    logic signed [OUT_W-1:0] r_x_reg;
    logic signed [OUT_W-1:0] r_y_reg;
    logic signed [OUT_W-1:0] r_z_reg;
    logic signed [OUT_W-1:0] scalar_reg;
    logic                    out_load;

    // pipe moves unless its last stage holds a word the output cannot take
    assign out_load = !out_valid_reg || out_ready;
    assign pipe_en  = !sq_valid || out_load;
    assign in_ready = pipe_en;

    assign a_vec[0] = a_w;
    assign a_vec[1] = a_x;
    assign a_vec[2] = a_y;
    assign a_vec[3] = a_z;
    assign b_vec[0] = b_w;
    assign b_vec[1] = b_x;
    assign b_vec[2] = b_y;
    assign b_vec[3] = b_z;

    // p*q covers both products; dot uses the diagonal, magnitude squares p
    always_comb
    begin
        p_next = a_vec;
        q_next = b_vec;
        unique case (qalu_func_t'(func)) inside
            FN_BA:
            begin
                p_next = b_vec;
                q_next = a_vec;
            end
            FN_CONJ_B, FN_MAG_B:
            begin
                p_next = b_vec;
                q_next = b_vec;
            end
            FN_MAG_A:
            begin
                q_next = a_vec;
            end
            default:
            begin
                p_next = a_vec;
                q_next = b_vec;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            func_a_reg <= qalu_func_t'(func);
            p_a_reg    <= p_next;
            q_a_reg    <= q_next;

            func_b_reg <= func_a_reg;
            p_b_reg    <= p_a_reg;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_b_reg[i][j] <= p_a_reg[i] * q_a_reg[j];
                end
            end

            side_c_reg <= side_next;
            rad_c_reg  <= d_sum[RAD_W-1:0];
        end
    end

    // four-term sums of the product array
    always_comb
    begin
        h_w = SUM_W'(prod_b_reg[0][0]) - SUM_W'(prod_b_reg[1][1])
            - SUM_W'(prod_b_reg[2][2]) - SUM_W'(prod_b_reg[3][3]);
        h_x = SUM_W'(prod_b_reg[0][1]) + SUM_W'(prod_b_reg[1][0])
            + SUM_W'(prod_b_reg[2][3]) - SUM_W'(prod_b_reg[3][2]);
        h_y = SUM_W'(prod_b_reg[0][2]) - SUM_W'(prod_b_reg[1][3])
            + SUM_W'(prod_b_reg[2][0]) + SUM_W'(prod_b_reg[3][1]);
        h_z = SUM_W'(prod_b_reg[0][3]) + SUM_W'(prod_b_reg[1][2])
            - SUM_W'(prod_b_reg[2][1]) + SUM_W'(prod_b_reg[3][0]);
        d_sum = SUM_W'(prod_b_reg[0][0]) + SUM_W'(prod_b_reg[1][1])
              + SUM_W'(prod_b_reg[2][2]) + SUM_W'(prod_b_reg[3][3]);

        side_next = '0;
        unique case (func_b_reg) inside
            FN_AB, FN_BA:
            begin
                side_next.r_w = OUT_W'(h_w);
                side_next.r_x = OUT_W'(h_x);
                side_next.r_y = OUT_W'(h_y);
                side_next.r_z = OUT_W'(h_z);
            end
            FN_DOT:
            begin
                side_next.scalar = OUT_W'(d_sum);
            end
            FN_CONJ_A, FN_CONJ_B:
            begin
                side_next.r_w = OUT_W'(p_b_reg[0]);
                side_next.r_x = -OUT_W'(p_b_reg[1]);
                side_next.r_y = -OUT_W'(p_b_reg[2]);
                side_next.r_z = -OUT_W'(p_b_reg[3]);
            end
            FN_MAG_A, FN_MAG_B:
            begin
                side_next.is_mag = 1'b1;
            end
            default:
            begin
                side_next = '0;
            end
        endcase
    end

    qalu_isqrt #(
        .RAD_W(RAD_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (vc_reg),
        .in_rad   (rad_c_reg),
        .in_side  (side_c_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            r_w_reg    <= sq_side.r_w;
            r_x_reg    <= sq_side.r_x;
            r_y_reg    <= sq_side.r_y;
            r_z_reg    <= sq_side.r_z;
            scalar_reg <= sq_side.is_mag ? OUT_W'(sq_root) : sq_side.scalar;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_w       = r_w_reg;
    assign r_x       = r_x_reg;
    assign r_y       = r_y_reg;
    assign r_z       = r_z_reg;
    assign scalar    = scalar_reg;

    `QA_ASSERT_NOW(a_full_blocks_input, clk, rst_n,
        sq_valid && out_valid_reg && !out_ready, !in_ready)
    `QA_ASSERT_NOW(a_quat_zero_scalar, clk, rst_n,
        out_valid && (r_w != 0 || r_x != 0 || r_y != 0 || r_z != 0), scalar == 0)
    `QA_ASSERT_NOW(a_mag_side_clear, clk, rst_n, sq_valid && sq_side.is_mag,
        sq_side.r_w == 0 && sq_side.r_x == 0 && sq_side.r_y == 0 &&
        sq_side.r_z == 0 && sq_side.scalar == 0)

endmodule

`default_nettype wire
